>>> design/eeprom_wear_level_ring_log_defines.svh
// assertion macros for the ring log controller
`ifndef EEPROM_WEAR_LEVEL_RING_LOG_DEFINES_SVH
`define EEPROM_WEAR_LEVEL_RING_LOG_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside reset
`define EWL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ring log check failed");

// condition implies another condition in the next cycle
`define EWL_ASSERT_NEXT(lbl, cond, expect_next) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_next)) \
      else $error("ring log sequencing check failed");

`else

`define EWL_ASSERT(lbl, prop)
`define EWL_ASSERT_NEXT(lbl, cond, expect_next)

`endif

`endif

>>> design/ewl_pkg.sv
package ewl_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   localparam logic [31:0] EMPTY_SEQ = 32'hFFFF_FFFF;
   localparam logic [31:0] TOP_SEQ   = 32'hFFFF_FFFE;
   localparam logic [15:0] EMPTY_VAL = 16'hFFFF;

   // request codes
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;
   localparam logic [1:0] REQ_HISTORY = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_SLOT_BYTES   = 2'd1;
   localparam logic [1:0] CSR_SLOTS_IN_USE = 2'd2;

   // result kinds
   localparam logic [1:0] OUT_ENTRY  = 2'd0;
   localparam logic [1:0] OUT_NODATA = 2'd1;
   localparam logic [1:0] OUT_FINAL  = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] new_value;
      logic [7:0]  history_count;
   } ewl_in_word_type;

   typedef struct packed {
      logic        status;
      logic [5:0]  slot_index;
      logic [15:0] byte_address;
      logic [31:0] sequence_number;
      logic [15:0] stored_value;
      logic [5:0]  empty_count;
      logic        last;
   } ewl_out_word_type;

   typedef struct packed {
      logic       start;
      logic       scan;
      logic       exec_write;
      logic       exec_clear;
      logic       sel_best;
      logic       hist_init;
      logic       hist_step;
      logic       load;
      logic [1:0] kind;
      logic       out_last;
   } ewl_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       found;
      logic       scan_last;
      logic       hist_left;
      logic       cur_empty;
      logic       out_free;
   } ewl_stat_type;

endpackage

>>> design/eeprom_wear_level_ring_log.sv
// Wear-levelling ring log over up to 16 slots of sequence number and value. One request is handled
// at a time: req_stall is low only while the block is idle. Every request first scans the
// ring one slot per cycle to find the newest entry; a write, read or clear then gives a
// single result word, held in the output register while rsp_stall is high. History walks
// the slots of its window, emitting each filled one as an entry word, then closes with a
// final word; when the ring holds an entry, that last word carries the number of empty
// slots in the window. Configuration writes are always taken (csr_ready stays high) but
// should only be issued while the block is idle; index 3 is ignored.
module eeprom_wear_level_ring_log
   import ewl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ewl_in_word_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ewl_out_word_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   ewl_cmd_type  cmd;
   ewl_stat_type stat;
   logic         csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   ewl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ewl_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/ewl_dp.sv
module ewl_dp
   import ewl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ewl_in_word_type  req_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata,
   input  ewl_cmd_type      cmd,
   output ewl_stat_type     stat,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output ewl_out_word_type rsp_data
);

   localparam int PW = IDX_W + 2;

   // configuration
   logic [15:0] base_ff;
   logic [7:0]  slot_bytes_ff;
   logic [4:0]  slots_ff;

   // slot store, valid bits stand in for the empty reset state
   logic [31:0]          seq_ff [MAX_SLOTS];
   logic [15:0]          val_ff [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] vld_ff;

   ewl_in_word_type  req_ff;
   logic [CNT_W-1:0] n_ff;
   logic [IDX_W-1:0] scan_idx_ff;
   logic [31:0]      best_seq_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             found_ff;
   logic [IDX_W-1:0] sel_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] empties_ff;

   ewl_out_word_type out_ff;
   logic             out_valid_ff;

   logic [CNT_W-1:0] n_in;
   logic             scan_filled;
   logic [31:0]      scan_seq;
   logic [IDX_W-1:0] wslot;
   logic [31:0]      wseq;
   logic [CNT_W-1:0] hist_cnt;
   logic [PW-1:0]    ptr_sum;
   logic [IDX_W-1:0] ptr_start;
   logic [IDX_W-1:0] ptr_next;
   logic             cur_empty;
   logic [IDX_W+7:0] addr_prod;
   ewl_out_word_type out_in;

   always_comb begin
      if (slots_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (32'(slots_ff) > MAX_SLOTS) begin
         n_in = CNT_W'(MAX_SLOTS);
      end else begin
         n_in = CNT_W'(slots_ff);
      end
   end

   assign scan_seq    = seq_ff[scan_idx_ff];
   assign scan_filled = vld_ff[scan_idx_ff] && (scan_seq != EMPTY_SEQ);

   // next slot after the newest, wrapping at the ring length
   always_comb begin
      if (!found_ff) begin
         wslot = '0;
         wseq  = 32'd1;
      end else begin
         wslot = (CNT_W'(best_idx_ff) == n_ff - CNT_W'(1)) ? '0 : best_idx_ff + IDX_W'(1);
         wseq  = (best_seq_ff >= TOP_SEQ) ? TOP_SEQ : best_seq_ff + 32'd1;
      end
   end

   // oldest slot of the history window: newest - (count - 1) around the ring
   assign hist_cnt  = (req_ff.history_count > 8'(n_ff)) ? n_ff : CNT_W'(req_ff.history_count);
   assign ptr_sum   = PW'(best_idx_ff) + PW'(n_ff) + PW'(1) - PW'(hist_cnt);
   assign ptr_start = (ptr_sum >= PW'(n_ff)) ? IDX_W'(ptr_sum - PW'(n_ff)) : IDX_W'(ptr_sum);
   assign ptr_next  = (CNT_W'(ptr_ff) == n_ff - CNT_W'(1)) ? '0 : ptr_ff + IDX_W'(1);
   assign cur_empty = !vld_ff[ptr_ff] || (seq_ff[ptr_ff] == EMPTY_SEQ);

   assign addr_prod = (IDX_W+8)'(sel_ff) * (IDX_W+8)'(slot_bytes_ff);

   always_comb begin
      out_in = '0;
      case (cmd.kind)
         OUT_ENTRY: begin
            out_in.slot_index      = 6'(sel_ff);
            out_in.byte_address    = base_ff + 16'(addr_prod);
            out_in.sequence_number = seq_ff[sel_ff];
            out_in.stored_value    = val_ff[sel_ff];
            out_in.last            = cmd.out_last;
         end
         OUT_NODATA: begin
            out_in.status = 1'b1;
            out_in.last   = 1'b1;
         end
         OUT_FINAL: begin
            out_in.empty_count = 6'(empties_ff);
            out_in.last        = 1'b1;
         end
         default: begin
            out_in.last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         slot_bytes_ff <= 8'd6;
         slots_ff      <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_ADDRESS: base_ff       <= csr_wdata;
            CSR_SLOT_BYTES:   slot_bytes_ff <= csr_wdata[7:0];
            CSR_SLOTS_IN_USE: slots_ff      <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.exec_clear) begin
         vld_ff <= '0;
      end else if (cmd.exec_write) begin
         vld_ff[wslot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_write) begin
         seq_ff[wslot] <= wseq;
         val_ff[wslot] <= req_ff.new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.start) begin
         found_ff <= 1'b0;
      end else if (cmd.scan && scan_filled) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff      <= req_data;
         n_ff        <= n_in;
         scan_idx_ff <= '0;
         empties_ff  <= '0;
         rem_ff      <= '0;
      end
      if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (scan_filled && (!found_ff || scan_seq >= best_seq_ff)) begin
            best_seq_ff <= scan_seq;
            best_idx_ff <= scan_idx_ff;
         end
      end
      if (cmd.exec_write) begin
         sel_ff <= wslot;
      end
      if (cmd.sel_best) begin
         sel_ff <= best_idx_ff;
      end
      if (cmd.hist_init) begin
         ptr_ff <= ptr_start;
         rem_ff <= hist_cnt;
      end
      if (cmd.hist_step) begin
         ptr_ff <= ptr_next;
         rem_ff <= rem_ff - CNT_W'(1);
         if (cur_empty) begin
            empties_ff <= empties_ff + CNT_W'(1);
         end else begin
            sel_ff <= ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_ff <= out_in;
      end
   end

   assign stat.req_type  = req_ff.req_type;
   assign stat.found     = found_ff;
   assign stat.scan_last = (CNT_W'(scan_idx_ff) == n_ff - CNT_W'(1));
   assign stat.hist_left = (rem_ff != '0);
   assign stat.cur_empty = cur_empty;
   assign stat.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> design/ewl_ctrl.sv
`include "eeprom_wear_level_ring_log_defines.svh"

module ewl_ctrl
   import ewl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ewl_stat_type stat,
   output ewl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_HIST = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] kind_ff;
   logic [1:0] kind_in;
   logic       hist_entry;

   // an entry found by the history walk is not the final word
   assign hist_entry = (kind_ff == OUT_ENTRY) && (stat.req_type == REQ_HISTORY);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_EMIT;
            case (stat.req_type)
               REQ_WRITE: begin
                  cmd.exec_write = 1'b1;
                  kind_in        = OUT_ENTRY;
               end
               REQ_READ: begin
                  cmd.sel_best = stat.found;
                  kind_in      = stat.found ? OUT_ENTRY : OUT_NODATA;
               end
               REQ_CLEAR: begin
                  cmd.exec_clear = 1'b1;
                  kind_in        = OUT_FINAL;
               end
               default: begin
                  if (stat.found) begin
                     cmd.hist_init = 1'b1;
                     state_in      = S_HIST;
                  end else begin
                     kind_in = OUT_NODATA;
                  end
               end
            endcase
         end
         S_HIST: begin
            if (!stat.hist_left) begin
               kind_in  = OUT_FINAL;
               state_in = S_EMIT;
            end else begin
               cmd.hist_step = 1'b1;
               if (!stat.cur_empty) begin
                  kind_in  = OUT_ENTRY;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            cmd.kind     = kind_ff;
            cmd.out_last = !hist_entry;
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = hist_entry ? S_HIST : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= OUT_FINAL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   `EWL_ASSERT_NEXT(a_accept_starts_scan, req_valid && !req_stall, state_ff == S_SCAN)
   `EWL_ASSERT(a_load_only_when_free, !cmd.load || stat.out_free)
   `EWL_ASSERT_NEXT(a_scan_ends_in_exec, state_ff == S_SCAN && stat.scan_last, state_ff == S_EXEC)
   `EWL_ASSERT(a_one_store_update, !(cmd.exec_write && cmd.exec_clear))

endmodule
